// ===== hw/rtl/tsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_pkg: shared types and constants
// Register indexes, input kinds, reset values and the control bundle
// passed from the trigger controller to the datapath.
// ----------------------------------------------------------------------------
package tsr_pkg;

	localparam int unsigned IDX_W  = 13;  // play index / length width
	localparam int unsigned GAIN_W = 17;  // magnitude of a 16-bit sample
	localparam int unsigned CNT_W  = 10;  // window and warmup counters
	localparam int unsigned GAIN_SHIFT = 15;

	localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;

	// configuration register indexes
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_LENGTH    = 2'd1;
	localparam logic [1:0] REG_WINDOW    = 2'd2;

	// input item kinds (tuser)
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_AUDIO = 1'b1;

	localparam logic signed [15:0] THRESHOLD_RST = 16'sd1000;
	localparam logic [IDX_W-1:0]   LENGTH_RST    = 13'd0;
	localparam logic [CNT_W-1:0]   WINDOW_RST    = 10'd500;

	typedef struct packed {
		logic              play;  // output carries a scaled word
		logic              hit;   // playback starts here
		logic [IDX_W-1:0]  idx;   // store word to read
		logic [GAIN_W-1:0] gain;
	} play_t;

endpackage

// ===== hw/rtl/tsr_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_store: sample memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tsr_store #(
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [15:0]              wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [15:0]              rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/tsr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_ctrl: trigger, peak window and playback control
// Advances the window, playback and warmup state by one audio sample per
// step and tells the datapath which word to read and with what gain.
// ----------------------------------------------------------------------------
module tsr_ctrl #(
	parameter int unsigned SAMPLE_DEPTH = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic signed [15:0]                  sample,
	input  logic signed [15:0]                  threshold,
	input  logic [tsr_pkg::IDX_W-1:0]           sample_length,
	input  logic [tsr_pkg::CNT_W-1:0]           peak_window,
	output tsr_pkg::play_t                      ctl
);

	localparam logic [16:0] DEPTH_17 = 17'(SAMPLE_DEPTH);

	logic [tsr_pkg::CNT_W-1:0]  wc_q, wc_n, wc_inc, wu_q, win;
	logic                       wa_q, wa_n, pa_q, pa_n, start;
	logic [tsr_pkg::GAIN_W-1:0] peak_q, peak_n, gain_q, gain_n, mag;
	logic [tsr_pkg::IDX_W-1:0]  pidx_q, pidx_n, pidx_cur, len;
	logic signed [16:0]         x17;
	logic                       pa_cur, rd, mask;

	always_comb begin
		win = (peak_window == '0) ? tsr_pkg::CNT_W'(1) : peak_window;
		len = ({4'b0, sample_length} > DEPTH_17) ? tsr_pkg::IDX_W'(SAMPLE_DEPTH)
		                                          : sample_length;
		x17 = 17'(sample);
		mag = (x17 < 0) ? tsr_pkg::GAIN_W'(-x17) : tsr_pkg::GAIN_W'(x17);
		wc_inc = (wc_q < tsr_pkg::COUNT_MAX) ? wc_q + 1'b1 : wc_q;

		wa_n = wa_q;
		wc_n = wc_q;
		peak_n = peak_q;
		start = 1'b0;
		if (wa_q) begin
			if (wc_q == '0) begin
				wa_n = 1'b0;   // extra blocked sample
			end else begin
				if (mag > peak_q) begin
					peak_n = mag;
				end
				wc_n = wc_inc;
				start = (wc_inc >= win);
			end
		end else if (sample > threshold) begin
			wa_n = 1'b1;
			peak_n = mag;
			wc_n = tsr_pkg::CNT_W'(1);
			start = (win == tsr_pkg::CNT_W'(1));
		end

		pa_cur = pa_q;
		pidx_cur = pidx_q;
		gain_n = gain_q;
		if (start) begin
			wc_n = '0;
			pidx_cur = '0;
			gain_n = peak_n;
			pa_cur = 1'b1;
		end

		rd = 1'b0;
		pa_n = pa_cur;
		pidx_n = pidx_cur;
		if (pa_cur) begin
			if (pidx_cur < len) begin
				rd = 1'b1;
				pidx_n = pidx_cur + 1'b1;
				if (pidx_n >= len) begin
					pa_n = 1'b0;
				end
			end else begin
				pa_n = 1'b0;
			end
		end

		mask = (wu_q < win - 1'b1);
		ctl.play = rd && !mask;
		ctl.hit  = start && !mask;
		ctl.idx  = pidx_cur;
		ctl.gain = gain_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q   <= '0;
			wa_q   <= 1'b0;
			peak_q <= '0;
			pa_q   <= 1'b0;
			pidx_q <= '0;
			gain_q <= '0;
			wu_q   <= '0;
		end else if (step) begin
			wc_q   <= wc_n;
			wa_q   <= wa_n;
			peak_q <= peak_n;
			pa_q   <= pa_n;
			pidx_q <= pidx_n;
			gain_q <= gain_n;
			if (wu_q < tsr_pkg::COUNT_MAX) begin
				wu_q <= wu_q + 1'b1;
			end
		end
	end

	// the counter is parked at zero whenever no window is open
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!wa_q |-> wc_q == '0)
		else $error("window count nonzero outside a window");

	// a new playback reads its first word unless the length is zero
	a_start_read: assert property (@(posedge clk) disable iff (!arst_n)
		step && start |-> (rd == (len != '0)) && pidx_cur == '0)
		else $error("playback start does not read word zero");

	// the gain never exceeds the magnitude of a full-scale sample
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= tsr_pkg::GAIN_W'(32768))
		else $error("gain out of range");

endmodule

// ===== hw/rtl/triggered_sample_replacer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triggered_sample_replacer_top: drum-trigger sample replacer
// Stores a replacement sample and plays it, scaled by the hit's peak level,
// each time the audio stream crosses the threshold.
// ----------------------------------------------------------------------------
// Load requests (tuser = 0) write one word of the sample memory; audio
// requests (tuser = 1) each yield exactly one output request. An audio sample
// above the signed threshold opens a peak window of peak_window samples; the
// window, plus one more sample, cannot retrigger. At the end of the window the
// stored sample is played from its first word, each word scaled by
// peak/32768 and truncated toward zero; a new trigger cuts off a running
// playback. Output is zero outside playback and for the first peak_window-1
// audio requests, so output lags input by peak_window-1 requests. The block
// takes one request per clock unless the output stalls, through an input
// register, a memory read register and an output register; the multiplier
// sits between the read and output registers. Load requests produce no output.
// Write configuration only while the stream is idle.
// ----------------------------------------------------------------------------
module triggered_sample_replacer_top #(
	parameter int unsigned SAMPLE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [11:0] load_address, [27:12] in_sample
	input  logic        s_axis_tuser,   // [0] action
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] out_sample
	output logic        m_axis_tuser,   // [0] hit_start
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int unsigned AW = $clog2(SAMPLE_DEPTH);

	// configuration registers
	logic signed [15:0]               thr_q;
	logic [tsr_pkg::IDX_W-1:0]        len_q;
	logic [tsr_pkg::CNT_W-1:0]        win_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= tsr_pkg::THRESHOLD_RST;
			len_q <= tsr_pkg::LENGTH_RST;
			win_q <= tsr_pkg::WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tsr_pkg::REG_THRESHOLD: thr_q <= cfg_data;
				tsr_pkg::REG_LENGTH:    len_q <= cfg_data[tsr_pkg::IDX_W-1:0];
				tsr_pkg::REG_WINDOW:    win_q <= cfg_data[tsr_pkg::CNT_W-1:0];
				default: ;  // unmapped index: ignored
			endcase
		end
	end

	// pipeline flow: each stage moves when the next one is empty or moving
	logic en_out, en2, en1, adv1, load, step;
	logic v_s1, v_s2, ov_q;

	assign en_out = !ov_q || m_axis_tready;
	assign en2    = !v_s2 || en_out;
	assign en1    = !v_s1 || en2;
	assign s_axis_tready = en1;

	// stage 1: input register
	logic              act_s1;
	logic [11:0]       addr_s1;
	logic signed [15:0] smp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_axis_tvalid) begin
			act_s1  <= s_axis_tuser;
			addr_s1 <= s_axis_tdata[11:0];
			smp_s1  <= s_axis_tdata[27:12];
		end
	end

	assign adv1 = v_s1 && en2;
	assign load = adv1 && (act_s1 == tsr_pkg::ACT_LOAD);
	assign step = adv1 && (act_s1 == tsr_pkg::ACT_AUDIO);

	// trigger / playback control
	tsr_pkg::play_t ctl;

	tsr_ctrl #(
		.SAMPLE_DEPTH (SAMPLE_DEPTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.sample        (smp_s1),
		.threshold     (thr_q),
		.sample_length (len_q),
		.peak_window   (win_q),
		.ctl           (ctl)
	);

	// sample memory; loads past the end are dropped
	logic [31:0]   waddr32, raddr32;
	logic          we;
	logic [15:0]   rdata_s2;

	assign waddr32 = 32'(addr_s1);
	assign raddr32 = 32'(ctl.idx);
	assign we      = load && (waddr32 < 32'(SAMPLE_DEPTH));

	tsr_store #(
		.DEPTH (SAMPLE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr32[AW-1:0]),
		.wdata (smp_s1),
		.re    (step),
		.raddr (raddr32[AW-1:0]),
		.rdata (rdata_s2)
	);

	// stage 2: read data alongside gain and flags
	logic                       play_s2, hit_s2;
	logic [tsr_pkg::GAIN_W-1:0] gain_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			play_s2 <= ctl.play;
			hit_s2  <= ctl.hit;
			gain_s2 <= ctl.gain;
		end
	end

	// scale: word * gain / 32768, truncated toward zero
	logic signed [33:0] prod, biased, quo;
	logic [15:0]        scaled;

	always_comb begin
		prod   = 34'($signed(rdata_s2)) * 34'($signed({1'b0, gain_s2}));
		biased = (prod < 0) ? prod + 34'sd32767 : prod;
		quo    = biased >>> tsr_pkg::GAIN_SHIFT;
		scaled = play_s2 ? quo[15:0] : 16'd0;
	end

	// output register
	logic [15:0] osmp_q;
	logic        ohit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en_out) begin
			ov_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			osmp_q <= scaled;
			ohit_q <= hit_s2;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = osmp_q;
	assign m_axis_tuser  = ohit_q;

	// every audio request leaving stage 1 reaches stage 2
	a_audio_moves: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> v_s2)
		else $error("audio request lost between stages");

	// loads never occupy the result path
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		load && !step |=> !v_s2)
		else $error("load request produced a result");

	// a stalled stage 2 keeps its read data for the output register
	a_hold_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !en2 |=> $stable(rdata_s2))
		else $error("read data changed while stage 2 stalled");

endmodule
